// ===== src/mtat_pkg.sv =====
// ----------------------------------------------------------------------------
// mtat_pkg
// Shared types and constants for the max tree argmax tracker.
// ----------------------------------------------------------------------------
package mtat_pkg;

  localparam int IdxW   = 10;
  localparam int TotW   = 32;
  localparam int CountW = 11;

  localparam logic signed [TotW-1:0] IntMin = {1'b1, {(TotW-1){1'b0}}};
  localparam logic signed [TotW-1:0] IntMax = {1'b0, {(TotW-1){1'b1}}};

  typedef logic signed [TotW-1:0] total_t;

  typedef struct packed {
    logic [IdxW-1:0] entry_index;
    total_t          amount;
  } item_t;

  typedef struct packed {
    logic [IdxW-1:0] best_index;
    total_t          best_total;
  } result_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLR_STEP,
    OP_LOAD,
    OP_LEAF_WR,
    OP_CLIMB,
    OP_DESC_INIT,
    OP_DESC_STEP
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic idx_live;
    logic climb_last;
    logic desc_last;
  } sts_t;

endpackage

// ===== src/mtat_ram.sv =====
// ----------------------------------------------------------------------------
// mtat_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mtat_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== src/mtat_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtat_ctrl
// Sequencer: clearing sweep, leaf update, climb to root, argmax descent.
// ----------------------------------------------------------------------------
module mtat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic          cfg_we_i,
  input  mtat_pkg::sts_t sts_i,
  output mtat_pkg::cmd_t cmd_o
);

  import mtat_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LEAF  = 3'd2;
  localparam logic [2:0] S_CLIMB = 3'd3;
  localparam logic [2:0] S_DESC0 = 3'd4;
  localparam logic [2:0] S_DESC  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLR_STEP;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LOAD;
          state_d  = sts_i.idx_live ? S_LEAF : S_DESC0;
        end
      end
      S_LEAF: begin
        cmd_o.op = OP_LEAF_WR;
        state_d  = S_CLIMB;
      end
      S_CLIMB: begin
        cmd_o.op = OP_CLIMB;
        if (sts_i.climb_last) state_d = S_DESC0;
      end
      S_DESC0: begin
        cmd_o.op = OP_DESC_INIT;
        state_d  = S_DESC;
      end
      S_DESC: begin
        cmd_o.op = OP_DESC_STEP;
        if (sts_i.desc_last) state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    // a count write restarts the clearing sweep
    if (cfg_we_i) begin
      cmd_o.op = OP_NONE;
      state_d  = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== src/mtat_dp.sv =====
// ----------------------------------------------------------------------------
// mtat_dp
// Datapath: tree memory, node pointer, running max and clearing sweep.
// ----------------------------------------------------------------------------
module mtat_dp #(
  parameter int LEAVES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mtat_pkg::cmd_t                  cmd_i,
  output mtat_pkg::sts_t                  sts_o,
  input  mtat_pkg::item_t                 item_i,
  input  logic                            cfg_we_i,
  input  logic [mtat_pkg::CountW-1:0]     cfg_wdata_i,
  output logic                            done_o,
  output mtat_pkg::result_t               result_o
);

  import mtat_pkg::*;

  localparam int Lvl   = $clog2(LEAVES);
  localparam int Pad   = 1 << Lvl;
  localparam int Aw    = Lvl + 1;
  localparam int Depth = 2 * Pad;
  localparam int Iw    = (Lvl > IdxW) ? Lvl : IdxW;
  localparam int Cw    = (Aw > CountW) ? Aw : CountW;
  localparam int CntMax = (1 << CountW) - 1;
  localparam logic [CountW-1:0] LeavesCnt =
    CountW'((LEAVES > CntMax) ? CntMax : LEAVES);
  localparam int RstRaw = LEAVES % (1 << CountW);
  localparam logic [CountW-1:0] RstLive = CountW'((RstRaw == 0) ? 1 : RstRaw);

  logic [Aw-1:0]     k_q, step_q, lo_q;
  logic [CountW-1:0] live_q, live_new;
  total_t            v_q, amt_q;
  logic              done_q;
  result_t           res_q;

  logic              we;
  logic [Aw-1:0]     waddr, raddr_a, raddr_b, leaf_in, k_nxt;
  logic [TotW-1:0]   wdata, rdata_a, rdata_b;
  total_t            rd_a, rd_b, sum_sat, max_v, chosen;
  logic [TotW:0]     sum_w;
  logic [Iw-1:0]     idx_w, best_w;
  logic              go_right;

  mtat_ram #(
    .Width(TotW),
    .Depth(Depth)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  assign rd_a = total_t'(rdata_a);
  assign rd_b = total_t'(rdata_b);

  assign idx_w   = Iw'(item_i.entry_index);
  assign leaf_in = {1'b1, idx_w[Lvl-1:0]};

  // saturating add onto the old leaf total
  assign sum_w   = {rd_a[TotW-1], rd_a} + {amt_q[TotW-1], amt_q};
  assign sum_sat = (sum_w[TotW] != sum_w[TotW-1]) ?
                   (sum_w[TotW] ? IntMin : IntMax) : total_t'(sum_w[TotW-1:0]);

  assign max_v    = (v_q >= rd_a) ? v_q : rd_a;
  assign go_right = !(rd_a >= rd_b);   // ties go left
  assign chosen   = go_right ? rd_b : rd_a;
  assign k_nxt    = {k_q[Aw-2:0], go_right};
  assign best_w   = Iw'(k_nxt[Lvl-1:0]);

  always_comb begin
    if (cfg_wdata_i == '0) begin
      live_new = CountW'(1);
    end else if (32'(cfg_wdata_i) > LEAVES) begin
      live_new = LeavesCnt;
    end else begin
      live_new = cfg_wdata_i;
    end
  end

  always_comb begin
    we      = 1'b0;
    waddr   = k_q;
    wdata   = sum_sat;
    raddr_a = k_q;
    raddr_b = k_q;
    case (cmd_i.op)
      OP_CLR_STEP: begin
        we    = 1'b1;
        wdata = (Cw'(lo_q) < Cw'(live_q)) ? '0 : IntMin;
      end
      OP_LOAD: begin
        raddr_a = leaf_in;
      end
      OP_LEAF_WR: begin
        we      = 1'b1;
        raddr_a = k_q ^ Aw'(1);
      end
      OP_CLIMB: begin
        we      = 1'b1;
        waddr   = k_q >> 1;
        wdata   = max_v;
        raddr_a = (k_q >> 1) ^ Aw'(1);
      end
      OP_DESC_INIT: begin
        raddr_a = Aw'(2);
        raddr_b = Aw'(3);
      end
      OP_DESC_STEP: begin
        raddr_a = {k_nxt[Aw-2:0], 1'b0};
        raddr_b = {k_nxt[Aw-2:0], 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= RstLive;
      k_q    <= Aw'(1);
      lo_q   <= '0;
      step_q <= Aw'(Pad);
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == OP_DESC_STEP) && sts_o.desc_last;
      if (cfg_we_i) begin
        live_q <= live_new;
        k_q    <= Aw'(1);
        lo_q   <= '0;
        step_q <= Aw'(Pad);
      end else begin
        case (cmd_i.op)
          OP_CLR_STEP: begin
            k_q <= k_q + Aw'(1);
            // last node of a level: halve the span, restart at the left
            if ((k_q & (k_q + Aw'(1))) == '0) begin
              step_q <= step_q >> 1;
              lo_q   <= '0;
            end else begin
              lo_q <= lo_q + step_q;
            end
          end
          OP_LOAD:      k_q <= leaf_in;
          OP_CLIMB:     k_q <= k_q >> 1;
          OP_DESC_INIT: k_q <= Aw'(1);
          OP_DESC_STEP: k_q <= k_nxt;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD:    amt_q <= item_i.amount;
      OP_LEAF_WR: v_q   <= sum_sat;
      OP_CLIMB:   v_q   <= max_v;
      OP_DESC_STEP: begin
        if (sts_o.desc_last) begin
          res_q.best_index <= best_w[IdxW-1:0];
          res_q.best_total <= chosen;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts_o.clr_last   = &k_q;
  assign sts_o.idx_live   = CountW'(item_i.entry_index) < live_q;
  assign sts_o.climb_last = (k_q[Aw-1:1] == (Aw-1)'(1));
  assign sts_o.desc_last  = k_q[Aw-2];

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== src/max_tree_argmax_tracker.sv =====
// ----------------------------------------------------------------------------
// max_tree_argmax_tracker
// Max tournament tree over signed entry totals with point update and argmax.
// ----------------------------------------------------------------------------
// done_o rises after the climb and the descent that follow the start cycle; an index
// past the count skips the climb.
// A new word waits until the last is done; start is taken again while done_o is high;
// one climb step and one descent step per cycle, each bound by the registered read.
// Reset and every count write run a clearing sweep over every tree node with busy high.
// The receiver cannot stall.
module max_tree_argmax_tracker #(
  parameter int LEAVES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mtat_pkg::item_t             item_i,
  output logic                        done_o,
  output mtat_pkg::result_t           result_o,
  input  logic                        cfg_we_i,
  input  logic [mtat_pkg::CountW-1:0] cfg_wdata_i
);

  import mtat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mtat_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cfg_we_i(cfg_we_i),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  mtat_dp #(
    .LEAVES(LEAVES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule

// ===== src/mtat_checker.sv =====
// ----------------------------------------------------------------------------
// mtat_checker
// Port-level checks for the max tree argmax tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mtat_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic cfg_we_i
);

  // a taken word keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted word");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !done_o)
    else $error("result strobe one cycle after accept");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("count write did not start clearing");

endmodule

bind max_tree_argmax_tracker mtat_checker u_mtat_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .cfg_we_i(cfg_we_i)
);
